[hw/rtl/jrs_pkg.sv]
// Shared types, constants and the CRC-32 byte step for the journal record scanner.
package jrs_pkg;

  localparam int unsigned MAX_IMAGE_BYTES = 65536;
  localparam int unsigned OFFSET_W        = 17;
  localparam int unsigned TOTAL_W         = 12;

  localparam logic [7:0]  ROW_MIN   = 8'd32;
  localparam logic [7:0]  CRC_BYTES = 8'd4;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ROW     = 3'd0,
    ST_END     = 3'd1,
    ST_TORN    = 3'd2,
    ST_BAD_LEN = 3'd3,
    ST_BAD_CRC = 3'd4,
    ST_BAD_VER = 3'd5
  } status_t;

  // One queue entry: an optional row result and an optional summary after it
  typedef struct packed {
    logic                has_row;
    logic                has_sum;
    logic [63:0]         record_uid;
    logic [31:0]         sequence_res;
    logic [31:0]         ordinal_value;
    logic [15:0]         sessions;
    logic [31:0]         dose_total;
    logic [15:0]         throttles;
    logic [7:0]          fault_bits;
    logic [7:0]          row_version;
    logic [7:0]          row_length;
    logic [OFFSET_W-1:0] row_offset;
    logic [TOTAL_W-1:0]  row_total;
    status_t             sum_status;
    logic [OFFSET_W-1:0] sum_offset;
    logic [TOTAL_W-1:0]  sum_total;
  } entry_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

[hw/rtl/jrs_result_queue.sv]
// Two-entry result queue; an entry holding a row and a summary leaves as two transfers.
module jrs_result_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jrs_pkg::entry_t    push_entry,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [63:0]        record_uid,
  output logic [31:0]        sequence_res,
  output logic [31:0]        ordinal_value,
  output logic [15:0]        sessions,
  output logic [31:0]        dose_total,
  output logic [15:0]        throttles,
  output logic [7:0]         fault_bits,
  output logic [7:0]         row_version,
  output logic [7:0]         row_length,
  output logic [16:0]        byte_offset,
  output logic [11:0]        row_total
);
  import jrs_pkg::*;

  entry_t      slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        phase;
  entry_t      head;
  logic        show_row;
  logic        xfer;
  logic        pop;

  assign head      = slots[rd_ptr];
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign show_row  = head.has_row && !phase;
  assign xfer      = out_valid && !out_stall;
  // entry retires after its last transfer
  assign pop       = xfer && !(head.has_row && head.has_sum && !phase);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers, fill count and row/summary phase
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      phase  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
        phase  <= 1'b0;
      end else if (xfer) begin
        phase  <= 1'b1;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Output selection: summaries carry zero row fields
  always_comb begin
    status        = show_row ? ST_ROW : head.sum_status;
    record_uid    = show_row ? head.record_uid    : '0;
    sequence_res  = show_row ? head.sequence_res  : '0;
    ordinal_value = show_row ? head.ordinal_value : '0;
    sessions      = show_row ? head.sessions      : '0;
    dose_total    = show_row ? head.dose_total    : '0;
    throttles     = show_row ? head.throttles     : '0;
    fault_bits    = show_row ? head.fault_bits    : '0;
    row_version   = show_row ? head.row_version   : '0;
    row_length    = show_row ? head.row_length    : '0;
    byte_offset   = show_row ? head.row_offset    : head.sum_offset;
    row_total     = show_row ? head.row_total     : head.sum_total;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result queue count out of range");

  a_phase_double: assert property (@(posedge clk) disable iff (rst)
    phase |-> (out_valid && head.has_row && head.has_sum))
    else $error("split phase on an entry without row and summary");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |=> (count == 2'd2 || $past(pop)))
    else $error("result queue lost an entry");

endmodule

[hw/rtl/journal_record_scanner_core.sv]
// Journal record scanner top level: byte register, row parser and CRC check.
//
// Usage: the journal image streams in one byte per transfer on data_byte,
// with last_byte high on the final byte. Each row gives its own length in
// its first byte and ends with a little-endian CRC-32 over the rest of it.
// A good row produces one result (status row) with its fixed fields; the
// final byte produces a summary (status, rows accepted, bytes of good rows).
// The first error (torn, bad length, bad crc, bad version) produces the
// summary at once; further bytes are dropped until last_byte, which rearms.
// Throughput: one byte per cycle while in_stall is low. The byte that causes
// a result is held in the input register, then the parser writes the result
// queue, which drives out_valid. A final byte that closes a good row yields
// two results, the row and then the summary, which leave as two transfers.
// Stall: results wait in a two-entry queue; when it is full and the input
// register holds a byte, in_stall rises until the queue retires an entry.
// Reset (rst, synchronous) empties the queue and returns the scanner to
// the start of an image.
module journal_record_scanner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [63:0] record_uid,
  output logic [31:0] sequence_res,
  output logic [31:0] ordinal_value,
  output logic [15:0] sessions,
  output logic [31:0] dose_total,
  output logic [15:0] throttles,
  output logic [7:0]  fault_bits,
  output logic [7:0]  row_version,
  output logic [7:0]  row_length,
  output logic [16:0] byte_offset,
  output logic [11:0] row_total
);
  import jrs_pkg::*;

  // input register
  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_last;
  logic                s1_go;

  // scan state
  logic [31:0]         crc_r,  crc_next;
  logic [7:0]          pos_r,  pos_next;
  logic [7:0]          decl_r, decl_next;
  logic [OFFSET_W-1:0] off_r,  off_next;
  logic [TOTAL_W-1:0]  rows_r, rows_next;
  logic                disc_r, disc_next;

  // captured row bytes
  logic [63:0]         cap0, cap1, cap2;
  logic [7:0]          fault_r, ver_r;
  logic [31:0]         stored_r;

  // parser signals
  logic [7:0]          rl;
  logic [31:0]         crc_in, crc_new;
  logic [8:0]          np;
  logic [17:0]         img_pos;
  logic                oversize;
  logic                tail_zone;
  logic                bad_len;
  logic                row_end;
  logic [31:0]         stored_full;
  logic                crc_ok;
  logic [2:0]          fld_idx;
  logic [1:0]          crc_idx;
  logic                fail;
  status_t             fail_st;
  logic                rearm;
  logic                push;
  entry_t              ent;
  logic                q_full;
  logic [TOTAL_W-1:0]  rows_inc;
  logic [OFFSET_W-1:0] off_inc;

  assign s1_go    = s1_valid && !q_full;
  assign in_stall = s1_valid && q_full;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  // Row geometry and CRC
  always_comb begin
    rl          = (pos_r == 8'd0) ? s1_byte : decl_r;
    crc_in      = (pos_r == 8'd0) ? CRC_INIT : crc_r;
    crc_new     = (rl >= CRC_BYTES && pos_r < rl - CRC_BYTES) ? crc_byte(crc_in, s1_byte)
                                                               : crc_in;
    np          = {1'b0, pos_r} + 9'd1;
    img_pos     = {1'b0, off_r} + {10'd0, pos_r};
    oversize    = img_pos >= 18'(MAX_IMAGE_BYTES);
    tail_zone   = (rl >= ROW_MIN) && (pos_r >= rl - CRC_BYTES);
    bad_len     = (np == {1'b0, ROW_MIN}) && (rl < ROW_MIN);
    row_end     = (rl >= ROW_MIN) && (np == {1'b0, rl});
    stored_full = {s1_byte, stored_r[23:0]};
    crc_ok      = (stored_full == ~crc_new);
    fld_idx     = pos_r[2:0] - 3'd2;
    crc_idx     = pos_r[1:0] - rl[1:0];
    rows_inc    = rows_r + 12'd1;
    off_inc     = off_r + OFFSET_W'(rl);
  end

  // Field capture
  always_ff @(posedge clk) begin
    if (s1_go && !disc_r) begin
      if (pos_r == 8'd1) begin
        ver_r <= s1_byte;
      end else if (pos_r >= 8'd2 && pos_r <= 8'd9) begin
        cap0[fld_idx*8 +: 8] <= s1_byte;
      end else if (pos_r >= 8'd10 && pos_r <= 8'd17) begin
        cap1[fld_idx*8 +: 8] <= s1_byte;
      end else if (pos_r >= 8'd18 && pos_r <= 8'd25) begin
        cap2[fld_idx*8 +: 8] <= s1_byte;
      end else if (pos_r == 8'd26) begin
        fault_r <= s1_byte;
      end
      if (tail_zone) begin
        stored_r[crc_idx*8 +: 8] <= s1_byte;
      end
    end
  end

  // Row checks and result building
  always_comb begin
    crc_next  = crc_r;
    pos_next  = pos_r;
    decl_next = decl_r;
    off_next  = off_r;
    rows_next = rows_r;
    disc_next = disc_r;
    fail      = 1'b0;
    fail_st   = ST_TORN;
    rearm     = 1'b0;
    push      = 1'b0;
    ent       = '0;

    if (s1_go) begin
      if (disc_r) begin
        rearm = s1_last;
      end else begin
        decl_next = rl;
        crc_next  = crc_new;
        pos_next  = np[7:0];
        if (oversize) begin
          fail = 1'b1;
        end else if (bad_len) begin
          fail    = 1'b1;
          fail_st = ST_BAD_LEN;
        end else if (row_end) begin
          if (!crc_ok) begin
            fail    = 1'b1;
            fail_st = ST_BAD_CRC;
          end else if (ver_r == 8'd0) begin
            fail    = 1'b1;
            fail_st = ST_BAD_VER;
          end else begin
            push              = 1'b1;
            ent.has_row       = 1'b1;
            ent.record_uid    = cap0;
            ent.sequence_res  = cap1[31:0];
            ent.ordinal_value = cap1[63:32];
            ent.sessions      = cap2[15:0];
            ent.dose_total    = cap2[47:16];
            ent.throttles     = cap2[63:48];
            ent.fault_bits    = fault_r;
            ent.row_version   = ver_r;
            ent.row_length    = rl;
            ent.row_offset    = off_r;
            ent.row_total     = rows_inc;
            rows_next         = rows_inc;
            off_next          = off_inc;
            pos_next          = 8'd0;
            if (s1_last) begin
              ent.has_sum    = 1'b1;
              ent.sum_status = ST_END;
              ent.sum_offset = off_inc;
              ent.sum_total  = rows_inc;
              rearm          = 1'b1;
            end
          end
        end else if (s1_last) begin
          fail = 1'b1;
        end

        // terminal error: summary now, then drop bytes or rearm
        if (fail) begin
          push           = 1'b1;
          ent.has_sum    = 1'b1;
          ent.sum_status = fail_st;
          ent.sum_offset = off_r;
          ent.sum_total  = rows_r;
          if (s1_last) begin
            rearm = 1'b1;
          end else begin
            disc_next = 1'b1;
          end
        end
      end

      if (rearm) begin
        crc_next  = CRC_INIT;
        pos_next  = 8'd0;
        decl_next = 8'd0;
        off_next  = '0;
        rows_next = '0;
        disc_next = 1'b0;
      end
    end
  end

  // Scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_r  <= CRC_INIT;
      pos_r  <= 8'd0;
      decl_r <= 8'd0;
      off_r  <= '0;
      rows_r <= '0;
      disc_r <= 1'b0;
    end else begin
      crc_r  <= crc_next;
      pos_r  <= pos_next;
      decl_r <= decl_next;
      off_r  <= off_next;
      rows_r <= rows_next;
      disc_r <= disc_next;
    end
  end

  jrs_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_entry   (ent),
    .full         (q_full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .record_uid   (record_uid),
    .sequence_res (sequence_res),
    .ordinal_value(ordinal_value),
    .sessions     (sessions),
    .dose_total   (dose_total),
    .throttles    (throttles),
    .fault_bits   (fault_bits),
    .row_version  (row_version),
    .row_length   (row_length),
    .byte_offset  (byte_offset),
    .row_total    (row_total)
  );

  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && disc_r) |-> !push)
    else $error("result produced while discarding");

  a_rearm_clean: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (pos_r == 8'd0 && rows_r == '0 && off_r == '0 && !disc_r))
    else $error("scanner not rearmed after final byte");

  a_row_counted: assert property (@(posedge clk) disable iff (rst)
    (push && ent.has_row) |-> (ent.row_total != '0 && ent.row_length >= ROW_MIN))
    else $error("row result with bad count or length");

endmodule
